/* sv/assert_macros.svh */
// Assertion macros shared by the byte literal parser RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define BLP_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define BLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/blp_pkg.sv */
// Shared types and constants for the byte literal parser.
// Used by blp_apb_regs, blp_parse_step and byte_literal_parser_core.
package blp_pkg;

  // Configuration port geometry.
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam logic [0:0]  RegValueLimit = 1'b0;
  localparam logic [7:0]  ValueLimitReset = 8'hFF;

  // Character codes the parser recognises.
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharOne    = 8'h31;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharUpperX = 8'h58;
  localparam logic [7:0] CharUpperB = 8'h42;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharVtab   = 8'h0B;
  localparam logic [7:0] CharFfeed  = 8'h0C;
  localparam logic [7:0] CharCr     = 8'h0D;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_SKIP  = 6'b000001,
    PH_ZERO  = 6'b000010,
    PH_DEC   = 6'b000100,
    PH_HEX   = 6'b001000,
    PH_BIN   = 6'b010000,
    PH_DRAIN = 6'b100000
  } phase_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_OOB     = 2'd2
  } status_e;

  // Per-line parser state.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] acc;
    logic       neg;
    logic       seen;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic [7:0] value;
    status_e    status;
  } literal_t;

endpackage

/* sv/byte_literal_parser_core.sv */
// Byte literal parser: one character per transaction in, one literal per line out.
//
// Usage:
//   Characters arrive on the s_axis channel, tdata carrying the ASCII code and
//   tlast marking the last character of a source line. Each line yields at most
//   one result on the m_axis channel: the parsed byte and a status of ok,
//   invalid or out of bounds. The limit for unsigned literals is written over
//   the APB port at byte address 0 and must only change while the block is idle.
// Datapath:
//   A character is taken into an input register; when the output register is
//   free or draining, it is parsed against the line state and any result lands
//   in the output register. One character is accepted every cycle while m_axis
//   does not stall; the parse step is a constant shift-add and compare between
//   these two registers.
// Reset:
//   Both registers empty, the line state at leading blank skip and the limit at 255.
// Stalls:
//   While a result waits on m_axis the input register holds its character and
//   s_axis_tready falls once that register is full; no transaction is lost.
// Depends on blp_pkg, blp_apb_regs, blp_parse_step and assert_macros.svh.
`include "assert_macros.svh"

module byte_literal_parser_core import blp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Character stream.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] char_code
  input  logic                    s_axis_tlast,   // end_of_line
  // Result stream.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [7:0] literal_value, [9:8] result_status
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_char_q;
  logic         in_eol_q;
  logic         out_valid_q, out_valid_d;
  literal_t     out_q;
  parse_state_t state_q, state_d;
  parse_state_t step_nxt;
  logic         step_emit;
  literal_t     step_result;
  logic [7:0]   value_limit;
  logic         advance;
  logic         in_take;

  // Register file.
  blp_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .value_limit_o (value_limit)
  );

  // Parse step on the registered character.
  blp_parse_step u_step (
    .cur_i         (state_q),
    .char_i        (in_char_q),
    .eol_i         (in_eol_q),
    .value_limit_i (value_limit),
    .nxt_o         (step_nxt),
    .emit_o        (step_emit),
    .result_o      (step_result)
  );

  // Handshake: the character moves on when the output register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Next values of the control registers.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && step_emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    state_d = state_q;
    if (advance) begin
      state_d = step_nxt;
    end
  end

  // Control and line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_SKIP, acc: 8'd0, neg: 1'b0, seen: 1'b0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_eol_q  <= s_axis_tlast;
    end
    if (advance && step_emit) begin
      out_q <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.value};

  // End of line always returns the parser to a clean blank skip.
  `BLP_ASSERT_NEXT(a_eol_clears, clk_i, rst_ni, advance && in_eol_q,
    (state_q.phase == PH_SKIP) && (state_q.acc == 8'd0) && !state_q.neg && !state_q.seen,
    "line state not cleared after end of line")
  // A line that is still open when it ends must produce a result.
  `BLP_ASSERT_NEXT(a_eol_result, clk_i, rst_ni,
    advance && in_eol_q && (state_q.phase != PH_DRAIN), out_valid_q,
    "open line ended without a result")
  // A result can only appear when a character has been parsed.
  `BLP_ASSERT_NEXT(a_result_source, clk_i, rst_ni, !advance && !out_valid_q, !out_valid_q,
    "result appeared without a parsed character")

endmodule

/* sv/blp_apb_regs.sv */
// APB register file of the byte literal parser: holds value_limit.
// Depends on blp_pkg for address width and reset value.
module blp_apb_regs import blp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output logic [7:0]              value_limit_o
);

  logic [7:0] limit_q, limit_d;
  logic       hit;

  // The register sits at word index zero; other words read as zero.
  assign hit    = (paddr[ApbAddrWidth-1:2] == RegValueLimit);
  assign pready = 1'b1;
  assign prdata = hit ? {{(ApbDataWidth-8){1'b0}}, limit_q} : '0;

  // Write on the access phase of a write transaction.
  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && hit) begin
      limit_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ValueLimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign value_limit_o = limit_q;

endmodule

/* sv/blp_parse_step.sv */
// Combinational per-character step of the literal parser: next state and result.
// Depends on blp_pkg for the state, result and character definitions.
module blp_parse_step import blp_pkg::*; (
  input  parse_state_t cur_i,
  input  logic [7:0]   char_i,
  input  logic         eol_i,
  input  logic [7:0]   value_limit_i,
  output parse_state_t nxt_o,
  output logic         emit_o,
  output literal_t     result_o
);

  logic       blank;
  logic       dec_ok;
  logic       bin_ok;
  logic       hex_ok;
  logic [3:0] dec_val;
  logic [3:0] hex_val;
  logic [8:0] lim;

  // Character classes, independent of the state.
  assign blank   = (char_i == CharSpace) || (char_i == CharTab) || (char_i == CharVtab) ||
                   (char_i == CharFfeed) || (char_i == CharCr);
  assign dec_ok  = (char_i >= CharZero) && (char_i <= CharNine);
  assign bin_ok  = (char_i == CharZero) || (char_i == CharOne);
  assign dec_val = char_i[3:0];
  assign hex_ok  = dec_ok || ((char_i >= CharUpperA) && (char_i <= CharUpperF)) ||
                   ((char_i >= CharLowerA) && (char_i <= CharLowerF));
  assign hex_val = dec_ok ? dec_val : (char_i[3:0] + 4'd9);

  always_comb begin
    parse_state_t nxt;
    logic         run;
    logic         emit;
    status_e      status;
    logic         dig_ok;
    logic [3:0]   dval;
    logic [11:0]  prod;
    logic [11:0]  sum;
    logic [7:0]   value;

    nxt    = cur_i;
    run    = 1'b0;
    emit   = 1'b0;
    status = ST_OK;
    dig_ok = 1'b0;
    dval   = 4'd0;
    prod   = 12'd0;
    sum    = 12'd0;
    value  = 8'd0;

    // Phase decisions on this character.
    unique case (cur_i.phase)
      PH_SKIP: begin
        if (!blank) begin
          nxt.acc  = 8'd0;
          nxt.neg  = 1'b0;
          nxt.seen = 1'b0;
          if (char_i == CharZero) begin
            nxt.phase = PH_ZERO;
            nxt.seen  = 1'b1;
          end else if (char_i == CharMinus) begin
            nxt.phase = PH_DEC;
            nxt.neg   = 1'b1;
          end else if (dec_ok) begin
            nxt.phase = PH_DEC;
            run       = 1'b1;
          end else begin
            nxt.phase = PH_DRAIN;
            emit      = 1'b1;
            status    = ST_INVALID;
          end
        end
      end
      PH_ZERO: begin
        if (char_i == CharUpperX) begin
          nxt.phase = PH_HEX;
          nxt.seen  = 1'b0;
        end else if (char_i == CharUpperB) begin
          nxt.phase = PH_BIN;
          nxt.seen  = 1'b0;
        end else begin
          nxt.phase = PH_DEC;
          run       = 1'b1;
        end
      end
      PH_DEC, PH_HEX, PH_BIN: begin
        run = 1'b1;
      end
      default: begin
        nxt.phase = PH_DRAIN;
      end
    endcase

    // Digit in the current base and the multiply-add by a constant shift pattern.
    if (nxt.phase == PH_HEX) begin
      dig_ok = hex_ok;
      dval   = hex_val;
      prod   = {nxt.acc, 4'b0000};
    end else if (nxt.phase == PH_BIN) begin
      dig_ok = bin_ok;
      dval   = dec_val;
      prod   = {3'b000, nxt.acc, 1'b0};
    end else begin
      dig_ok = dec_ok;
      dval   = dec_val;
      prod   = {1'b0, nxt.acc, 3'b000} + {3'b000, nxt.acc, 1'b0};
    end
    sum = prod + {8'd0, dval};

    // Accept the digit, or close the literal on a non-digit or an overflow.
    if (run) begin
      if (!dig_ok) begin
        emit      = 1'b1;
        status    = nxt.seen ? ST_OK : ST_INVALID;
        nxt.phase = PH_DRAIN;
      end else if (sum > {3'b000, lim}) begin
        emit      = 1'b1;
        status    = ST_OOB;
        nxt.phase = PH_DRAIN;
      end else begin
        nxt.acc  = sum[7:0];
        nxt.seen = 1'b1;
      end
    end

    // End of line forces a result if none was given on this line.
    if (eol_i && !emit && (nxt.phase != PH_DRAIN)) begin
      emit   = 1'b1;
      status = ((nxt.phase != PH_SKIP) && nxt.seen) ? ST_OK : ST_INVALID;
    end

    // Negative literals leave as two's complement.
    if (nxt.phase != PH_SKIP) begin
      value = nxt.neg ? (8'd0 - nxt.acc) : nxt.acc;
    end

    if (eol_i) begin
      nxt.phase = PH_SKIP;
      nxt.acc   = 8'd0;
      nxt.neg   = 1'b0;
      nxt.seen  = 1'b0;
    end

    nxt_o           = nxt;
    emit_o          = emit;
    result_o.value  = value;
    result_o.status = status;
  end

  // Limit for negative literals is half the limit plus one.
  assign lim = cur_i.neg && (cur_i.phase != PH_SKIP) ?
               ({2'b00, value_limit_i[7:1]} + 9'd1) : {1'b0, value_limit_i};

endmodule

/* test/byte_literal_parser_core_test.sv */
// Self-checking testbench for byte_literal_parser_core: drives source lines one character
// per transaction, predicts each line's literal and checks every result in order.
// Depends on blp_pkg and the byte_literal_parser_core RTL only.
`timescale 1ns / 100ps

module byte_literal_parser_core_test import blp_pkg::*; ();

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseChars = 300;
  localparam logic [ApbAddrWidth-1:0] LimitAddr = {RegValueLimit, 2'b00};
  localparam logic [7:0] BlankCodes [5] = '{CharSpace, CharTab, CharVtab, CharFfeed, CharCr};

  typedef logic [7:0] char_list_t[$];

  typedef struct {
    logic [7:0] code;
    logic       eol;
  } source_char_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = 8'h00;   // [7:0] char_code
  logic                    s_axis_tlast = 1'b0;    // end_of_line
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [15:0]             m_axis_tdata;           // [7:0] literal_value, [9:8] result_status
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ApbAddrWidth-1:0] paddr = '0;
  logic [ApbDataWidth-1:0] pwdata = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  // Characters waiting to be sent and literals waiting to arrive.
  source_char_t char_queue[$];
  literal_t     pending_literals[$];
  int unsigned  chars_pending = 0;
  int unsigned  chars_sent = 0;
  int unsigned  literals_checked = 0;
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  // Predicted line state and the limit currently programmed.
  logic [7:0] limit_setting = ValueLimitReset;
  phase_e     line_phase = PH_SKIP;
  logic [7:0] line_acc = 8'h00;
  logic       line_neg = 1'b0;
  logic       line_seen = 1'b0;

  byte_literal_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock and a single reset pulse at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Safety net against a hung handshake.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles", CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Closes the line with a literal and ignores the rest of it.
  task automatic emit_literal(input status_e status);
    literal_t lit;
    lit.value = line_neg ? (8'd0 - line_acc) : line_acc;
    lit.status = status;
    pending_literals.push_back(lit);
    line_phase = PH_DRAIN;
  endtask

  // Accumulates one digit in the given base, or ends the literal.
  task automatic step_digit(input int base, input logic [7:0] code, output bit made);
    int c;
    int d;
    int lim;
    int nxt;
    c = code;
    d = -1;
    made = 1'b0;
    if (c >= CharZero && c <= CharNine && c - CharZero < base) begin
      d = c - CharZero;
    end else if (base == 16 && c >= CharUpperA && c <= CharUpperF) begin
      d = c - CharUpperA + 10;
    end else if (base == 16 && c >= CharLowerA && c <= CharLowerF) begin
      d = c - CharLowerA + 10;
    end
    if (d < 0) begin
      emit_literal(line_seen ? ST_OK : ST_INVALID);
      made = 1'b1;
    end else begin
      lim = limit_setting;
      if (line_neg) lim = lim / 2 + 1;
      nxt = int'(line_acc) * base + d;
      if (nxt > lim) begin
        emit_literal(ST_OOB);
        made = 1'b1;
      end else begin
        line_acc = nxt[7:0];
        line_seen = 1'b1;
      end
    end
  endtask

  // Works out the result, if any, that one accepted character causes.
  task automatic parse_char(input logic [7:0] code, input logic eol);
    bit made;
    made = 1'b0;
    unique case (line_phase)
      PH_SKIP: begin
        if (!(code == CharSpace || code == CharTab || code == CharVtab ||
              code == CharFfeed || code == CharCr)) begin
          line_acc = 8'h00;
          line_neg = 1'b0;
          line_seen = 1'b0;
          if (code == CharZero) begin
            line_phase = PH_ZERO;
            line_seen = 1'b1;
          end else if (code == CharMinus) begin
            line_neg = 1'b1;
            line_phase = PH_DEC;
          end else if (code >= CharOne && code <= CharNine) begin
            line_phase = PH_DEC;
            step_digit(10, code, made);
          end else begin
            emit_literal(ST_INVALID);
            made = 1'b1;
          end
        end
      end
      PH_ZERO: begin
        if (code == CharUpperX) begin
          line_phase = PH_HEX;
          line_seen = 1'b0;
        end else if (code == CharUpperB) begin
          line_phase = PH_BIN;
          line_seen = 1'b0;
        end else begin
          line_phase = PH_DEC;
          step_digit(10, code, made);
        end
      end
      PH_DEC: step_digit(10, code, made);
      PH_HEX: step_digit(16, code, made);
      PH_BIN: step_digit(2, code, made);
      default: line_phase = PH_DRAIN;
    endcase
    // End of line closes an open literal and rearms the blank skip.
    if (eol) begin
      if (!made && line_phase != PH_DRAIN) begin
        if (line_phase == PH_SKIP) begin
          line_acc = 8'h00;
          line_neg = 1'b0;
          line_seen = 1'b0;
        end
        emit_literal(line_seen ? ST_OK : ST_INVALID);
      end
      line_phase = PH_SKIP;
      line_acc = 8'h00;
      line_neg = 1'b0;
      line_seen = 1'b0;
    end
  endtask

  // Sender: presents queued characters, idling at random when asked to.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, s_axis_tlast);
        chars_pending--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= char_queue[0].code;
          s_axis_tlast <= char_queue[0].eol;
          void'(char_queue.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_literals.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", m_axis_tdata));
        end else begin
          if (m_axis_tdata[7:0] !== pending_literals[0].value) begin
            report_mismatch($sformatf("value %h, expected %h", m_axis_tdata[7:0],
                                      pending_literals[0].value));
          end
          if (m_axis_tdata[9:8] !== pending_literals[0].status) begin
            report_mismatch($sformatf("status %0d, expected %s", m_axis_tdata[9:8],
                                      pending_literals[0].status.name()));
          end
          void'(pending_literals.pop_front());
        end
        literals_checked++;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queues one source line; its last character carries the end-of-line flag.
  task automatic queue_chars(input char_list_t chars);
    source_char_t item;
    for (int i = 0; i < chars.size(); i++) begin
      item.code = chars[i];
      item.eol = (i == chars.size() - 1);
      char_queue.push_back(item);
      chars_pending++;
      chars_sent++;
    end
  endtask

  task automatic queue_text(input string text);
    char_list_t chars;
    for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
    queue_chars(chars);
  endtask

  // Mostly well-formed literals near the limit, plus broken prefixes and noise.
  task automatic queue_random_line();
    char_list_t chars;
    string text;
    int kind;
    int value;
    int lim;
    logic [7:0] ch;
    kind = $urandom_range(99);
    repeat ($urandom_range(2)) chars.push_back(BlankCodes[$urandom_range(4)]);
    lim = (kind >= 30 && kind < 50) ? limit_setting / 2 + 1 : limit_setting;
    case ($urandom_range(3))
      0: value = $urandom_range(999);
      1: value = lim + 1 - $urandom_range(2);
      default: value = $urandom_range(lim);
    endcase
    if (kind < 30) begin
      text = $sformatf("%0d", value);
      if ($urandom_range(3) == 0) text = {"0", text};
    end else if (kind < 50) begin
      text = $sformatf("-%0d", value);
    end else if (kind < 65) begin
      text = $sformatf("0X%0h", value);
    end else if (kind < 78) begin
      text = $sformatf("0B%0b", value);
    end else if (kind < 90) begin
      case ($urandom_range(5))
        0: text = "0X";
        1: text = "0B";
        2: text = "-";
        3: text = "0x";
        4: text = "0b";
        default: text = "";
      endcase
    end else begin
      text = "";
    end
    for (int i = 0; i < text.len(); i++) begin
      ch = text[i];
      // Hex digits come out in either case.
      if (kind >= 50 && kind < 65 && i >= 2 && ch >= CharLowerA && ch <= CharLowerF &&
          $urandom_range(1) == 1) begin
        ch = ch - 8'h20;
      end
      chars.push_back(ch);
    end
    if (kind >= 90) begin
      repeat ($urandom_range(6, 1)) chars.push_back(8'($urandom_range(255)));
    end else if ($urandom_range(1) == 1) begin
      repeat ($urandom_range(4, 1)) chars.push_back(8'($urandom_range(255)));
    end
    if (chars.size() == 0) chars.push_back(BlankCodes[$urandom_range(4)]);
    queue_chars(chars);
  endtask

  // Waits until every character is taken and every literal has come back.
  task automatic wait_until_idle();
    while (chars_pending != 0 || pending_literals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LimitAddr;
    pwdata <= {{(ApbDataWidth - 8){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_setting = value;
  endtask

  task automatic apb_check_limit();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LimitAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== limit_setting) begin
      report_mismatch($sformatf("limit reads %h, expected %h", prdata[7:0], limit_setting));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus: directed lines, then random phases over limits and handshake patterns.
  initial begin
    char_list_t special;
    int unsigned limit_plan [6];
    int unsigned phase_start;
    limit_plan = '{1, 127, 255, 10, 0, 2};
    limit_plan[4] = $urandom_range(255, 1);
    @(posedge rst_ni);
    apb_check_limit();

    queue_text(" 0XfF");
    queue_text("0B1,");
    queue_text("-129");
    queue_text("\t;");
    queue_text("\r");
    queue_text("0x");
    queue_text("256");
    queue_text("-");
    queue_text("0B2");
    special = {8'h00};
    queue_chars(special);
    special = {8'hFF};
    queue_chars(special);
    wait_until_idle();

    for (int p = 0; p < 6; p++) begin
      apb_write(limit_plan[p][7:0]);
      apb_check_limit();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      // The sender pauses halfway until every literal so far has arrived.
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseChars / 2) queue_random_line();
      wait_until_idle();
      while (chars_sent - phase_start < PhaseChars) queue_random_line();
      wait_until_idle();
    end

    $display("Sent %0d characters and checked %0d literals over %0d limit settings,",
             chars_sent, literals_checked, 7);
    $display("with free-running, sender-idle, receiver-stall and mixed handshakes.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
